[src/tcce_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell engine package
// Screen geometry, field widths, character codes and the command and status
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int SHIFT_CELLS   = SCREEN_WIDTH * (SCREEN_HEIGHT - 1);
    localparam int TAB_STOP      = 8;
    localparam int TAB_LIMIT     = SCREEN_WIDTH - 9;

    localparam int COL_W  = $clog2(SCREEN_WIDTH + 1);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT + 1);
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CIDX_W = 11;
    localparam int CELL_W = 16;

    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'd13;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

    typedef struct packed {
        logic accept;
        logic exec;
        logic clear_step;
        logic copy_step;
        logic zero_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic copy_last;
        logic zero_last;
        logic scroll;
        logic out_free;
    } t_status;

endpackage

[src/tcce_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell engine controller
// Sequences the screen clear after reset, request execution, the scroll
// copy and zero sweeps, and the hand-over of each result.
// ----------------------------------------------------------------------------
module tcce_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  tcce_pkg::t_status i_status,
    output tcce_pkg::t_cmd   o_cmd
);
    import tcce_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_COPY  = 3'd3;
    localparam logic [2:0] ST_ZERO  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_stall = !((r_state == ST_IDLE) ||
                          ((r_state == ST_DONE) && i_status.out_free));
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.accept = accept;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_status.scroll ? ST_COPY : ST_DONE;
            end
            ST_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_status.copy_last) begin
                    n_state = ST_ZERO;
                end
            end
            ST_ZERO: begin
                o_cmd.zero_step = 1'b1;
                if (i_status.zero_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hand the result over, and take the next request alongside
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = accept ? ST_EXEC : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/tcce_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell engine datapath
// Cursor, text attribute, screen memory with its sweep counter, and the
// result register.
// ----------------------------------------------------------------------------
module tcce_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcce_pkg::t_cmd                i_cmd,
    output tcce_pkg::t_status             o_status,
    input  logic                          i_cfg_we,
    input  logic [tcce_pkg::ATTR_W-1:0]   i_cfg_data,
    input  logic                          i_req_type,
    input  logic [tcce_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcce_pkg::CIDX_W-1:0]   i_cell_index,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [tcce_pkg::CIDX_W-1:0]   o_cursor_index,
    output logic [tcce_pkg::CELL_W-1:0]   o_cell_entry,
    output logic                          o_scrolled
);
    import tcce_pkg::*;

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rd_data;

    logic [ATTR_W-1:0] r_attr;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_ctr;
    logic              r_req;
    logic [CHAR_W-1:0] r_char;
    logic [CIDX_W-1:0] r_index;
    logic              r_rd_ok;
    logic              r_scrolled;

    logic              r_out_valid;
    logic [CIDX_W-1:0] r_out_cursor;
    logic [CELL_W-1:0] r_out_entry;
    logic              r_out_scrolled;

    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic              n_scroll;
    logic              is_print;
    logic [ADDR_W-1:0] pos;
    logic              in_range;
    logic              do_put;
    logic              do_read;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    assign pos      = ADDR_W'(r_row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(r_col);
    assign in_range = 32'(r_index) < CELL_COUNT;
    assign do_put   = i_cmd.exec && (r_req == REQ_PUT);
    assign do_read  = i_cmd.exec && (r_req == REQ_READ);
    assign is_print = (r_char != CODE_NEWLINE) && (r_char != CODE_TAB) &&
                      (r_char != CODE_BACKSPACE) && (r_char != CODE_RETURN);

    // cursor movement for one put request
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_scroll = 1'b0;
        case (r_char)
            CODE_NEWLINE: begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end
            CODE_TAB: begin
                if (32'(r_col) < TAB_LIMIT) begin
                    n_col = (r_col + COL_W'(TAB_STOP)) & ~COL_W'(TAB_STOP - 1);
                end
            end
            CODE_BACKSPACE: begin
                if (r_col == '0) begin
                    if (r_row != '0) begin
                        n_col = COL_W'(SCREEN_WIDTH - 1);
                        n_row = r_row - ROW_W'(1);
                    end
                end else begin
                    n_col = r_col - COL_W'(1);
                end
            end
            CODE_RETURN: begin
                n_col = '0;
            end
            default: begin
                n_col = r_col + COL_W'(1);
                if (n_col >= COL_W'(SCREEN_WIDTH)) begin
                    n_col = '0;
                    n_row = r_row + ROW_W'(1);
                end
            end
        endcase
        if (n_row >= ROW_W'(SCREEN_HEIGHT)) begin
            n_row    = ROW_W'(SCREEN_HEIGHT - 1);
            n_scroll = 1'b1;
        end
    end

    // memory port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ctr;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = r_ctr + ADDR_W'(SCREEN_WIDTH);
        if (i_cmd.clear_step) begin
            wr_en   = 1'b1;
            wr_data = BLANK_CELL;
        end else if (do_put) begin
            wr_en   = is_print;
            wr_addr = pos;
            wr_data = {r_attr, r_char};
        end else if (i_cmd.copy_step) begin
            // write back what the previous step read one row below
            wr_en   = (r_ctr != '0);
            wr_addr = r_ctr - ADDR_W'(1);
            wr_data = r_rd_data;
            rd_en   = 32'(r_ctr) < SHIFT_CELLS;
        end else if (i_cmd.zero_step) begin
            wr_en   = 1'b1;
        end
        if (do_read) begin
            rd_en   = in_range;
            rd_addr = ADDR_W'(r_index);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr      <= RESET_ATTR;
            r_col       <= '0;
            r_row       <= '0;
            r_ctr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            if (do_put) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cmd.exec) begin
                r_ctr <= '0;
            end else if (i_cmd.clear_step || i_cmd.zero_step) begin
                r_ctr <= r_ctr + ADDR_W'(1);
            end else if (i_cmd.copy_step && (32'(r_ctr) < SHIFT_CELLS)) begin
                r_ctr <= r_ctr + ADDR_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req   <= i_req_type;
            r_char  <= i_char_code;
            r_index <= i_cell_index;
        end
        if (i_cmd.exec) begin
            r_rd_ok    <= (r_req == REQ_READ) && in_range;
            r_scrolled <= do_put && n_scroll;
        end
        if (i_cmd.load_out) begin
            r_out_cursor   <= CIDX_W'(pos);
            r_out_entry    <= r_rd_ok ? r_rd_data : '0;
            r_out_scrolled <= r_scrolled;
        end
    end

    assign o_status.clear_last = (r_ctr == ADDR_W'(CELL_COUNT - 1));
    assign o_status.copy_last  = (r_ctr == ADDR_W'(SHIFT_CELLS));
    assign o_status.zero_last  = (r_ctr == ADDR_W'(CELL_COUNT - 1));
    assign o_status.scroll     = do_put && n_scroll;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_cursor_index = r_out_cursor;
    assign o_cell_entry   = r_out_entry;
    assign o_scrolled     = r_out_scrolled;

endmodule

[src/text_console_cell_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell engine
// 80x25 character-cell terminal: cursor handling, screen memory and scroll.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one request: a put of
// i_char_code at the cursor, or a read of the cell at i_cell_index. Output
// channel (o_out_valid / i_out_stall) returns one result per request: the
// cursor index, the read cell (zero for puts) and a scroll flag.
// i_cfg_we writes the text attribute used for new characters.
//
// A request without scroll is executed against the screen memory, then its
// result register is loaded, and in that state the next request is taken
// once the output is free. A put that scrolls walks the memory one cell a
// cycle: a copy sweep that moves each row up by one, then a zero sweep over
// the last row, before its result appears.
// After reset the block clears every cell to a grey space, one cell a
// cycle, with o_in_stall high; configuration writes are taken throughout.
// While the receiver stalls, the result is held and at most one further
// request is taken and executed.
// ----------------------------------------------------------------------------
module text_console_cell_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tcce_pkg::ATTR_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [tcce_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcce_pkg::CIDX_W-1:0]   i_cell_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tcce_pkg::CIDX_W-1:0]   o_cursor_index,
    output logic [tcce_pkg::CELL_W-1:0]   o_cell_entry,
    output logic                          o_scrolled
);
    import tcce_pkg::*;

    t_cmd    cmd;
    t_status status;

    tcce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tcce_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req_type),
        .i_char_code    (i_char_code),
        .i_cell_index   (i_cell_index),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_cursor_index (o_cursor_index),
        .o_cell_entry   (o_cell_entry),
        .o_scrolled     (o_scrolled)
    );

endmodule

[src/tcce_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell engine checker
// Port-level properties of the result channel, attached by bind.
// ----------------------------------------------------------------------------
module tcce_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [tcce_pkg::CIDX_W-1:0]   o_cursor_index,
    input  logic [tcce_pkg::CELL_W-1:0]   o_cell_entry,
    input  logic                          o_scrolled
);
    import tcce_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cursor_index) &&
        $stable(o_cell_entry) && $stable(o_scrolled))
        else $error("stalled result changed");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_cursor_index) < CELL_COUNT)
        else $error("cursor index beyond screen");

    // a scroll always leaves the cursor on the last row
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scrolled |-> 32'(o_cursor_index) >= SHIFT_CELLS)
        else $error("scroll left cursor above last row");

    // reads never scroll and puts return no cell
    a_entry_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_cell_entry != '0) |-> !o_scrolled)
        else $error("cell entry reported with a scroll");

endmodule

bind text_console_cell_engine tcce_checker u_tcce_checker (.*);

[tb/tb_text_console_cell_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell engine testbench
// Sends put and read requests with random gaps on both channels, keeps a
// behavioural copy of the cursor, the attribute and the screen, and checks
// every result field by field against it, including scrolls and backpressure.
// ----------------------------------------------------------------------------
module tb_text_console_cell_engine;
    import tcce_pkg::*;

    typedef struct packed {
        logic              req_type;
        logic [CHAR_W-1:0] char_code;
        logic [CIDX_W-1:0] cell_index;
    } console_req_t;

    typedef struct packed {
        logic [CIDX_W-1:0] cursor_index;
        logic [CELL_W-1:0] cell_entry;
        logic              scrolled;
    } console_res_t;

    localparam int HOLD_OFF_CYCLES = 80;
    localparam int TAIL_CYCLES     = 40;
    localparam int RANDOM_BLOCKS   = 8;
    localparam int BLOCK_REQUESTS  = 100;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [ATTR_W-1:0] i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_req_type;
    logic [CHAR_W-1:0] i_char_code;
    logic [CIDX_W-1:0] i_cell_index;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [CIDX_W-1:0] o_cursor_index;
    logic [CELL_W-1:0] o_cell_entry;
    logic              o_scrolled;

    // Behavioural copy of the console
    logic [CELL_W-1:0] screen_image [CELL_COUNT];
    logic [ATTR_W-1:0] text_attr;
    int                cur_col;
    int                cur_row;

    console_res_t      pending_results [$];
    int                mismatch_count;
    int                put_count;
    int                read_count;
    int                scroll_count;
    int                attr_writes;
    bit                idle_enable;
    int                receiver_hold_cycles;

    text_console_cell_engine u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_char_code    (i_char_code),
        .i_cell_index   (i_cell_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cursor_index (o_cursor_index),
        .o_cell_entry   (o_cell_entry),
        .o_scrolled     (o_scrolled)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one request to the console copy and return the result it gives
    function automatic console_res_t apply_request(input console_req_t rq);
        console_res_t rs;
        int           pos;
        int           i;
        rs = '0;
        if (rq.req_type == REQ_READ) begin
            if (rq.cell_index < CELL_COUNT)
                rs.cell_entry = screen_image[rq.cell_index];
        end else begin
            case (rq.char_code)
                CODE_NEWLINE: begin
                    cur_col = 0;
                    cur_row++;
                end
                CODE_TAB: begin
                    if (cur_col < TAB_LIMIT)
                        cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
                end
                CODE_BACKSPACE: begin
                    if (cur_col == 0) begin
                        if (cur_row != 0) begin
                            cur_col = SCREEN_WIDTH - 1;
                            cur_row--;
                        end
                    end else begin
                        cur_col--;
                    end
                end
                CODE_RETURN: begin
                    cur_col = 0;
                end
                default: begin
                    pos = cur_row * SCREEN_WIDTH + cur_col;
                    if (pos < CELL_COUNT)
                        screen_image[pos] = {text_attr, rq.char_code};
                    cur_col++;
                    if (cur_col >= SCREEN_WIDTH) begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
            endcase
            if (cur_row >= SCREEN_HEIGHT) begin
                for (i = 0; i < SHIFT_CELLS; i++)
                    screen_image[i] = screen_image[i + SCREEN_WIDTH];
                for (i = SHIFT_CELLS; i < CELL_COUNT; i++)
                    screen_image[i] = '0;
                cur_row = SCREEN_HEIGHT - 1;
                rs.scrolled = 1'b1;
            end
        end
        rs.cursor_index = CIDX_W'(cur_row * SCREEN_WIDTH + cur_col);
        return rs;
    endfunction

    function automatic logic [CHAR_W-1:0] printable_code();
        logic [CHAR_W-1:0] code;
        do
            code = CHAR_W'($urandom_range(0, 255));
        while (code == CODE_NEWLINE || code == CODE_TAB ||
               code == CODE_BACKSPACE || code == CODE_RETURN);
        return code;
    endfunction

    function automatic console_req_t put_request(input logic [CHAR_W-1:0] code);
        console_req_t rq;
        rq.req_type   = REQ_PUT;
        rq.char_code  = code;
        rq.cell_index = CIDX_W'($urandom_range(0, 2047));
        return rq;
    endfunction

    function automatic console_req_t read_request(input int index);
        console_req_t rq;
        rq.req_type   = REQ_READ;
        rq.char_code  = CHAR_W'($urandom_range(0, 255));
        rq.cell_index = CIDX_W'(index);
        return rq;
    endfunction

    // Mostly characters, some control codes, reads near the cursor and anywhere
    function automatic console_req_t random_request();
        console_req_t rq;
        int           pick;
        int           near;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            near = cur_row * SCREEN_WIDTH + cur_col - int'($urandom_range(0, 2 * SCREEN_WIDTH));
            rq = read_request((near < 0) ? 0 : near);
        end else if (pick < 25)
            rq = read_request($urandom_range(0, 2047));
        else if (pick < 27)
            rq = put_request(CODE_NEWLINE);
        else if (pick < 31)
            rq = put_request(CODE_RETURN);
        else if (pick < 35)
            rq = put_request(CODE_TAB);
        else if (pick < 41)
            rq = put_request(CODE_BACKSPACE);
        else
            rq = put_request(printable_code());
        return rq;
    endfunction

    // Offer one request, hold it until taken, then record what it should return
    task automatic send_request(input console_req_t rq);
        int           gap;
        console_res_t rs;
        gap = idle_enable ? $urandom_range(0, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_req_type   = rq.req_type;
        i_char_code  = rq.char_code;
        i_cell_index = rq.cell_index;
        do @(posedge i_clk); while (o_in_stall);
        rs = apply_request(rq);
        pending_results.push_back(rs);
        if (rq.req_type == REQ_READ)
            read_count++;
        else
            put_count++;
        if (rs.scrolled)
            scroll_count++;
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_text_attr(input logic [ATTR_W-1:0] value);
        wait_results_drained();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        text_attr  = value;
        attr_writes++;
    endtask

    task automatic test_reset_state();
        write_text_attr(8'hFF);
        send_request(read_request(0));
        send_request(read_request(CELL_COUNT - 1));
        send_request(read_request(2047));
    endtask

    task automatic test_character_extremes();
        // backspace at the top-left must leave the cursor alone
        send_request(put_request(CODE_BACKSPACE));
        send_request(put_request(8'h00));
        send_request(put_request(8'hFF));
        send_request(put_request(8'h80));
        send_request(read_request(0));
        send_request(read_request(1));
        send_request(read_request(2));
    endtask

    task automatic test_cursor_codes();
        // tab up to the last stop, then once more where it must not move
        repeat (10) send_request(put_request(CODE_TAB));
        send_request(put_request(CODE_RETURN));
        send_request(put_request(CODE_NEWLINE));
        send_request(put_request(CODE_BACKSPACE));
        send_request(put_request(8'h41));
        send_request(read_request(SCREEN_WIDTH - 1));
        send_request(put_request(8'h7E));
        send_request(put_request(CODE_BACKSPACE));
        send_request(read_request(CELL_COUNT));
    endtask

    task automatic test_scroll_lines();
        int line;
        int len;
        write_text_attr(8'h00);
        idle_enable = 1'b1;
        for (line = 0; line < SCREEN_HEIGHT + 1; line++) begin
            len = $urandom_range(0, 24);
            repeat (len) send_request(put_request(printable_code()));
            send_request(put_request(CODE_NEWLINE));
        end
        // a full line on the bottom row wraps and scrolls again
        repeat (SCREEN_WIDTH) send_request(put_request(printable_code()));
        repeat (10) send_request(read_request($urandom_range(SHIFT_CELLS - SCREEN_WIDTH,
                                                              CELL_COUNT - 1)));
    endtask

    task automatic test_long_stall();
        receiver_hold_cycles = HOLD_OFF_CYCLES;
        repeat (30) send_request(random_request());
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int blk;
        for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            write_text_attr(ATTR_W'($urandom_range(0, 255)));
            idle_enable = (blk != 1 && blk != 5);
            repeat (BLOCK_REQUESTS) send_request(random_request());
        end
        idle_enable = 1'b1;
    endtask

    initial begin
        int i;
        for (i = 0; i < CELL_COUNT; i++)
            screen_image[i] = BLANK_CELL;
        text_attr            = RESET_ATTR;
        cur_col              = 0;
        cur_row              = 0;
        mismatch_count       = 0;
        put_count            = 0;
        read_count           = 0;
        scroll_count         = 0;
        attr_writes          = 0;
        idle_enable          = 1'b1;
        receiver_hold_cycles = 0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_data           = '0;
        i_in_valid           = 1'b0;
        i_req_type           = REQ_PUT;
        i_char_code          = '0;
        i_cell_index         = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_character_extremes();
        test_cursor_codes();
        test_scroll_lines();
        test_long_stall();
        test_random_traffic();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d puts and %0d reads, %0d of them scrolling, under %0d attributes",
                 put_count, read_count, scroll_count, attr_writes);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result side: draw a stall per result, or take a long hold-off when asked
    initial begin : result_receiver
        int wait_cycles;
        i_out_stall = 1'b0;
        forever begin
            if (receiver_hold_cycles > 0) begin
                wait_cycles = receiver_hold_cycles;
                receiver_hold_cycles = 0;
            end else begin
                wait_cycles = idle_enable ? $urandom_range(0, 4) : 0;
            end
            @(negedge i_clk);
            i_out_stall = (wait_cycles > 0);
            if (wait_cycles > 0) begin
                repeat (wait_cycles) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin : result_check
        console_res_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: cursor_index %0d", o_cursor_index);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_cursor_index !== want.cursor_index) begin
                    $error("cursor_index: expected %0d, got %0d",
                           want.cursor_index, o_cursor_index);
                    mismatch_count++;
                end
                if (o_cell_entry !== want.cell_entry) begin
                    $error("cell_entry: expected %04h, got %04h",
                           want.cell_entry, o_cell_entry);
                    mismatch_count++;
                end
                if (o_scrolled !== want.scrolled) begin
                    $error("scrolled: expected %0b, got %0b", want.scrolled, o_scrolled);
                    mismatch_count++;
                end
            end
        end
    end

    // Allows every request to scroll and wait out the longest gaps, several times over
    initial begin
        #32_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
src/tcce_pkg.sv
src/tcce_ctrl.sv
src/tcce_datapath.sv
src/text_console_cell_engine.sv
src/tcce_checker.sv
tb/tb_text_console_cell_engine.sv
